// ===== sv/channel_mailbox_engine_core_macros.svh =====
// Assertion macros for the channel mailbox engine core.
`ifndef CHANNEL_MAILBOX_ENGINE_CORE_MACROS_SVH
`define CHANNEL_MAILBOX_ENGINE_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CME_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CME_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== sv/cme_pkg.sv =====
// Package with types and constants of the channel mailbox engine.
package cme_pkg;
  localparam int NUM_CHANNELS_D = 16;
  localparam int MAX_ROOM_D     = 8;
  localparam int MAX_WAITERS_D  = 8;
  localparam int VALUE_WIDTH_D  = 32;
  localparam int GEN_WIDTH_D    = 16;

  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_SEND  = 2'd1;
  localparam logic [1:0] KIND_RECV  = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  localparam logic [3:0] CODE_TRUE   = 4'd0;
  localparam logic [3:0] CODE_FALSE  = 4'd1;
  localparam logic [3:0] CODE_NONE   = 4'd2;
  localparam logic [3:0] CODE_SOME   = 4'd3;
  localparam logic [3:0] CODE_PARKED = 4'd4;
  localparam logic [3:0] CODE_UNIT   = 4'd5;
  localparam logic [3:0] CODE_HANDLE = 4'd6;
  localparam logic [3:0] CODE_FULL   = 4'd7;
  localparam logic [3:0] CODE_OVFL   = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_WAKE, ST_CLOSE_RD, ST_CLOSE_EM, ST_ANSWER
  } state_t;
endpackage

// ===== sv/cme_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module cme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/channel_mailbox_engine_core.sv =====
// Channel mailbox engine: request sequencer over row, ring and waiter memories.
// Open, send and receive pass through the read, execute, wake and answer states; a wake-up
// goes out in the wake slot. Close passes through read and close-read, then close-emit and
// close-read again per parked waiter, then answer. One request is in flight at a time; the
// next transfer is accepted in the cycle after the answer is loaded.
// Synchronous active-low reset clears the row table; ring and waiter memories need no clearing.
module channel_mailbox_engine_core
  import cme_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_D,
  parameter int MAX_ROOM     = MAX_ROOM_D,
  parameter int MAX_WAITERS  = MAX_WAITERS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[1:0], handle_index[5:2], handle_gen[21:6], payload[53:22],
  // capacity[57:54], requester_id[65:58], zero fill
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // to_waiter[0], waiter_id[8:1], code[12:9], data_out[44:13],
  // new_index[48:45], new_gen[64:49], zero fill
  output logic [71:0] out_tdata,
  output logic        out_tlast
);
  localparam int RW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HW = (MAX_ROOM > 1) ? $clog2(MAX_ROOM) : 1;
  localparam int WW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CW = $clog2(MAX_ROOM + 1);
  localparam int KW = $clog2(MAX_WAITERS + 1);
  localparam int FW = $clog2(NUM_CHANNELS + 1);
  localparam int WSW = 32 + 8 + 1;
  localparam int RD = NUM_CHANNELS * MAX_ROOM;
  localparam int WD = NUM_CHANNELS * MAX_WAITERS;
  localparam int RAW = $clog2(RD) > 0 ? $clog2(RD) : 1;
  localparam int WAW = $clog2(WD) > 0 ? $clog2(WD) : 1;
  localparam logic [WW:0] WMOD = (WW+1)'(MAX_WAITERS);

  // Row table (flip-flops, small)
  logic                     live_r   [NUM_CHANNELS];
  logic                     closed_r [NUM_CHANNELS];
  logic [15:0]              gen_r    [NUM_CHANNELS];
  logic [CW-1:0]            room_r   [NUM_CHANNELS];
  logic [HW-1:0]            rhead_r  [NUM_CHANNELS];
  logic [CW-1:0]            rcnt_r   [NUM_CHANNELS];
  logic [WW-1:0]            whead_r  [NUM_CHANNELS];
  logic [KW-1:0]            wcnt_r   [NUM_CHANNELS];
  logic [RW-1:0]            fstack_r [NUM_CHANNELS];
  logic [FW-1:0]            ftop_r, fresh_r;

  state_t state_r, state_nxt;
  logic [1:0]  kind_r;
  logic [31:0] pay_r;
  logic [3:0]  cap_r;
  logic [7:0]  rid_r;
  logic [RW-1:0] row_r;
  logic          ok_r;

  // Output register
  logic        ov_r, olast_r, oto_r;
  logic [7:0]  oid_r;
  logic [3:0]  ocode_r;
  logic [31:0] odata_r;
  logic [3:0]  oidx_r;
  logic [15:0] ogen_r;

  // Memories
  logic           ring_we, wait_we;
  logic [RAW-1:0] ring_wa, ring_ra;
  logic [WAW-1:0] wait_wa, wait_ra;
  logic [31:0]    ring_wd, ring_rd;
  logic [WSW-1:0] wait_wd, wait_rd;

  cme_ram #(.WIDTH(32), .DEPTH(RD)) u_ring (
    .clk, .we(ring_we), .waddr(ring_wa), .wdata(ring_wd), .raddr(ring_ra), .rdata(ring_rd));
  cme_ram #(.WIDTH(WSW), .DEPTH(WD)) u_wait (
    .clk, .we(wait_we), .waddr(wait_wa), .wdata(wait_wd), .raddr(wait_ra), .rdata(wait_rd));

  logic in_fire, out_free;
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Derived row fields for the latched row
  logic [CW-1:0] room_c, rcnt_c;
  logic [KW-1:0] wcnt_c;
  logic [HW-1:0] rhead_c;
  logic [WW-1:0] whead_c;
  logic          closed_c;
  assign room_c   = room_r[row_r];
  assign rcnt_c   = rcnt_r[row_r];
  assign wcnt_c   = wcnt_r[row_r];
  assign rhead_c  = rhead_r[row_r];
  assign whead_c  = whead_r[row_r];
  assign closed_c = closed_r[row_r];

  function automatic logic [HW-1:0] ring_wrap(input logic [CW:0] v, input logic [CW-1:0] m);
    logic [CW:0] t;
    t = (v >= {1'b0, m}) ? v - {1'b0, m} : v;
    return t[HW-1:0];
  endfunction

  // Waiter queue tail and head advance, wrapped by compare and subtract
  logic [WW:0]   wtail_s, whead_s;
  logic [WW-1:0] wtail, whead_inc;
  assign wtail_s   = {1'b0, whead_c} + {1'b0, WW'(wcnt_c)};
  assign wtail     = (wtail_s >= WMOD) ? WW'(wtail_s - WMOD) : WW'(wtail_s);
  assign whead_s   = {1'b0, whead_c} + 1'b1;
  assign whead_inc = (whead_s >= WMOD) ? WW'(whead_s - WMOD) : WW'(whead_s);

  logic front_sender;
  assign front_sender = wait_rd[0];
  logic [7:0]  front_id;
  logic [31:0] front_val;
  assign front_id  = wait_rd[8:1];
  assign front_val = wait_rd[40:9];

  // Read addresses follow the latched row heads
  assign ring_ra = RAW'(row_r) * RAW'(MAX_ROOM) + RAW'(rhead_c);
  assign wait_ra = WAW'(row_r) * WAW'(MAX_WAITERS) + WAW'(whead_c);

  // Result staged for the answer
  logic [3:0]  acode_r;
  logic [31:0] adata_r;
  logic [3:0]  aidx_r;
  logic [15:0] agen_r;
  logic [7:0]  wid_r;
  logic [3:0]  wcode_r;
  logic [31:0] wdat_r;

  logic [CW:0] rtail_s;
  assign rtail_s = {1'b0, CW'(rhead_c)} + {1'b0, rcnt_c};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_READ;
      ST_READ:     state_nxt = (kind_r == KIND_CLOSE && ok_r && !closed_c) ?
                               ST_CLOSE_RD : ST_EXEC;
      ST_EXEC:     state_nxt = ST_WAKE;
      ST_WAKE:     if (out_free) state_nxt = ST_ANSWER;
      ST_CLOSE_RD: state_nxt = (wcnt_c == '0) ? ST_ANSWER : ST_CLOSE_EM;
      ST_CLOSE_EM: if (out_free) state_nxt = ST_CLOSE_RD;
      ST_ANSWER:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  logic wake_v_r;

  // Output register loads a result in these states
  logic ov_set;
  assign ov_set = out_free && ((state_r == ST_WAKE && wake_v_r) ||
                               state_r == ST_CLOSE_EM || state_r == ST_ANSWER);

  // Datapath and state updates
  always_ff @(posedge clk) begin
    logic        ring_we_v, wait_we_v, wake_v;
    logic [3:0]  wcode_v, aidx_v;
    logic [31:0] wdat_v, adata_v;
    logic [15:0] agen_v;
    ring_we_v = 1'b0;
    wait_we_v = 1'b0;
    wake_v    = 1'b0;
    wcode_v   = CODE_TRUE;
    wdat_v    = '0;
    adata_v   = '0;
    aidx_v    = '0;
    agen_v    = '0;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ftop_r  <= '0;
      fresh_r <= '0;
      ov_r    <= 1'b0;
      wake_v_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        live_r[i] <= 1'b0; closed_r[i] <= 1'b0; gen_r[i] <= '0; room_r[i] <= '0;
        rhead_r[i] <= '0; rcnt_r[i] <= '0; whead_r[i] <= '0; wcnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_set || (ov_r && !out_tready);
      case (state_r)
        ST_IDLE: if (in_fire) begin
          kind_r <= in_tdata[1:0];
          pay_r  <= in_tdata[53:22];
          cap_r  <= in_tdata[57:54];
          rid_r  <= in_tdata[65:58];
          row_r  <= RW'(in_tdata[5:2]);
          ok_r   <= ({28'd0, in_tdata[5:2]} < 32'(fresh_r)) &&
                    ({28'd0, in_tdata[5:2]} < 32'(NUM_CHANNELS)) &&
                    live_r[RW'(in_tdata[5:2])] && gen_r[RW'(in_tdata[5:2])] == in_tdata[21:6];
        end
        ST_READ: ;
        ST_EXEC: begin
          wid_r <= front_id;
          case (kind_r)
            KIND_OPEN: begin
              if (ftop_r != '0 || 32'(fresh_r) < 32'(NUM_CHANNELS)) begin : op
                logic [RW-1:0] i;
                logic [15:0] g;
                if (ftop_r != '0) begin
                  i = fstack_r[RW'(ftop_r - 1'b1)];
                  g = gen_r[i] + 1'b1;
                  ftop_r <= ftop_r - 1'b1;
                end else begin
                  i = RW'(fresh_r);
                  g = 16'd1;
                  fresh_r <= fresh_r + 1'b1;
                end
                gen_r[i] <= g; live_r[i] <= 1'b1; closed_r[i] <= 1'b0;
                room_r[i] <= (32'(cap_r) > 32'(MAX_ROOM)) ? CW'(MAX_ROOM) : CW'(cap_r);
                rhead_r[i] <= '0; rcnt_r[i] <= '0; whead_r[i] <= '0; wcnt_r[i] <= '0;
                acode_r <= CODE_HANDLE; aidx_v = 4'(i); agen_v = g;
              end else acode_r <= CODE_FULL;
            end
            KIND_SEND: begin
              if (!ok_r || closed_c) acode_r <= CODE_FALSE;
              else if (wcnt_c != '0 && !front_sender) begin
                wake_v = 1'b1; wcode_v = CODE_SOME; wdat_v = pay_r;
                whead_r[row_r] <= whead_inc; wcnt_r[row_r] <= wcnt_c - 1'b1;
                acode_r <= CODE_TRUE;
              end else if (rcnt_c < room_c) begin
                ring_we_v = 1'b1; ring_wd <= pay_r;
                ring_wa <= RAW'(row_r) * RAW'(MAX_ROOM) + RAW'(ring_wrap(rtail_s, room_c));
                rcnt_r[row_r] <= rcnt_c + 1'b1;
                acode_r <= CODE_TRUE;
              end else if (32'(wcnt_c) >= 32'(MAX_WAITERS)) acode_r <= CODE_OVFL;
              else begin
                wait_we_v = 1'b1; wait_wd <= {pay_r, rid_r, 1'b1};
                wait_wa <= WAW'(row_r) * WAW'(MAX_WAITERS) + WAW'(wtail);
                wcnt_r[row_r] <= wcnt_c + 1'b1; acode_r <= CODE_PARKED;
              end
            end
            KIND_RECV: begin
              if (!ok_r) acode_r <= CODE_NONE;
              else if (rcnt_c != '0 && room_c != '0) begin : rv
                logic [HW-1:0] nh;
                logic [CW-1:0] nc;
                logic [CW:0]   ts;
                nh = ring_wrap({1'b0, CW'(rhead_c)} + 1'b1, room_c);
                nc = rcnt_c - 1'b1;
                rhead_r[row_r] <= nh;
                acode_r <= CODE_SOME; adata_v = ring_rd;
                if (wcnt_c != '0 && front_sender) begin
                  wake_v = 1'b1;
                  whead_r[row_r] <= whead_inc; wcnt_r[row_r] <= wcnt_c - 1'b1;
                  ts = {1'b0, CW'(nh)} + {1'b0, nc};
                  ring_we_v = 1'b1; ring_wd <= front_val;
                  ring_wa <= RAW'(row_r) * RAW'(MAX_ROOM) + RAW'(ring_wrap(ts, room_c));
                  nc = nc + 1'b1;
                end
                rcnt_r[row_r] <= nc;
                if (closed_c && nc == '0) begin
                  live_r[row_r] <= 1'b0;
                  if (32'(ftop_r) < 32'(NUM_CHANNELS)) begin
                    fstack_r[RW'(ftop_r)] <= row_r; ftop_r <= ftop_r + 1'b1;
                  end
                end
              end else if (wcnt_c != '0 && front_sender) begin
                wake_v = 1'b1;
                whead_r[row_r] <= whead_inc; wcnt_r[row_r] <= wcnt_c - 1'b1;
                acode_r <= CODE_SOME; adata_v = front_val;
              end else if (closed_c) begin
                live_r[row_r] <= 1'b0;
                if (32'(ftop_r) < 32'(NUM_CHANNELS)) begin
                  fstack_r[RW'(ftop_r)] <= row_r; ftop_r <= ftop_r + 1'b1;
                end
                acode_r <= CODE_NONE;
              end else if (32'(wcnt_c) >= 32'(MAX_WAITERS)) acode_r <= CODE_OVFL;
              else begin
                wait_we_v = 1'b1; wait_wd <= {32'd0, rid_r, 1'b0};
                wait_wa <= WAW'(row_r) * WAW'(MAX_WAITERS) + WAW'(wtail);
                wcnt_r[row_r] <= wcnt_c + 1'b1; acode_r <= CODE_PARKED;
              end
            end
            default: acode_r <= CODE_UNIT;
          endcase
          wake_v_r <= wake_v; wcode_r <= wcode_v; wdat_r <= wdat_v;
          adata_r <= adata_v; aidx_r <= aidx_v; agen_r <= agen_v;
        end
        ST_WAKE: if (out_free && wake_v_r) begin
          oto_r <= 1'b1; oid_r <= wid_r; ocode_r <= wcode_r;
          odata_r <= wdat_r; oidx_r <= '0; ogen_r <= '0; olast_r <= 1'b0;
        end
        ST_CLOSE_RD: begin
          closed_r[row_r] <= 1'b1;
          acode_r <= CODE_UNIT; adata_r <= '0; aidx_r <= '0; agen_r <= '0;
          if (wcnt_c == '0 && rcnt_c == '0) begin
            live_r[row_r] <= 1'b0;
            if (32'(ftop_r) < 32'(NUM_CHANNELS)) begin
              fstack_r[RW'(ftop_r)] <= row_r; ftop_r <= ftop_r + 1'b1;
            end
          end
        end
        ST_CLOSE_EM: if (out_free) begin
          oto_r <= 1'b1; oid_r <= front_id;
          ocode_r <= front_sender ? CODE_FALSE : CODE_NONE;
          odata_r <= '0; oidx_r <= '0; ogen_r <= '0; olast_r <= 1'b0;
          whead_r[row_r] <= whead_inc; wcnt_r[row_r] <= wcnt_c - 1'b1;
        end
        ST_ANSWER: if (out_free) begin
          oto_r <= 1'b0; oid_r <= rid_r; ocode_r <= acode_r;
          odata_r <= adata_r; oidx_r <= aidx_r; ogen_r <= agen_r; olast_r <= 1'b1;
        end
        default: ;
      endcase
    end
    ring_we <= ring_we_v;
    wait_we <= wait_we_v;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {7'd0, ogen_r, oidx_r, odata_r, ocode_r, oid_r, oto_r};

  `include "channel_mailbox_engine_core_macros.svh"
  `CME_ASSERT_IMP(a_busy_no_ready, clk, rst_n, state_r != ST_IDLE, !in_tready)
  `CME_ASSERT_NEXT(a_stall_holds, clk, rst_n, ov_r && !out_tready, ov_r && $stable(out_tdata))
  `CME_ASSERT_IMP(a_ftop_range, clk, rst_n, 1'b1, 32'(ftop_r) <= 32'(NUM_CHANNELS))
endmodule
